### rtl/core/pqm_pkg.sv
package pqm_pkg;

  localparam int unsigned KindW = 2;
  localparam int unsigned ProtoW = 16;
  localparam int unsigned SlotW = 3;
  localparam int unsigned LenW = 11;
  localparam int unsigned StatusW = 4;
  localparam int unsigned PktW = 5;
  localparam logic [LenW-1:0] MinLength = 11'd14;
  localparam logic [LenW-1:0] MaxLengthReset = 11'd1514;

  typedef enum logic [KindW-1:0] {
    KIND_OPEN    = 2'd0,
    KIND_CLOSE   = 2'd1,
    KIND_DELIVER = 2'd2,
    KIND_READ    = 2'd3
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK           = 4'd0,
    ST_PROTO_IN_USE = 4'd1,
    ST_NO_FREE_CONN = 4'd2,
    ST_BAD_HANDLE   = 4'd3,
    ST_BAD_SIZE     = 4'd4,
    ST_NO_BUFFER    = 4'd5,
    ST_NO_RECEIVER  = 4'd6,
    ST_EMPTY        = 4'd7,
    ST_WINDOW_SMALL = 4'd8
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CONN_SCAN,
    S_BUF_SCAN,
    S_CLOSE_RD,
    S_CLOSE_WALK,
    S_READ_RD,
    S_READ_DONE,
    S_OUT
  } state_e;

  typedef struct packed {
    logic [KindW-1:0]   kind;
    logic [ProtoW-1:0]  protocol;
    logic [SlotW-1:0]   conn_index;
    logic [LenW-1:0]    length;
  } req_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [SlotW-1:0]   conn_result;
    logic [PktW-1:0]    packet_index;
    logic [LenW-1:0]    length_result;
  } rsp_t;

endpackage

### rtl/core/pqm_req_if.sv
interface pqm_req_if;
  logic          valid;
  logic          ready;
  pqm_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/core/pqm_rsp_if.sv
interface pqm_rsp_if;
  logic          valid;
  logic          ready;
  pqm_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/core/pqm_cfg_if.sv
interface pqm_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [pqm_pkg::LenW-1:0]   data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/core/pqm_ram.sv
module pqm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/core/packet_queue_manager.sv
// Each operation runs in one sequencer, and the block is not ready until its
// result is taken. Open and deliver scan the connection table one slot a cycle;
// a deliver of valid size first scans the buffer pool one buffer a cycle for a
// free buffer. Read fetches the head packet of the connection and then frees it;
// close frees the queued packets in order, walking them through the single read
// port of the link memory. Configuration writes are taken at any time.
module packet_queue_manager #(
  parameter int unsigned CONN_SLOTS = 8,
  parameter int unsigned BUFFER_COUNT = 32
) (
  input logic clk_i,
  input logic rst_ni,
  pqm_req_if.sink   req,
  pqm_rsp_if.source rsp,
  pqm_cfg_if.sink   cfg
);

  localparam int unsigned CW = (CONN_SLOTS > 1) ? $clog2(CONN_SLOTS) : 1;
  localparam int unsigned BW = (BUFFER_COUNT > 1) ? $clog2(BUFFER_COUNT) : 1;
  localparam int unsigned SlotWx = pqm_pkg::SlotW;

  logic [pqm_pkg::LenW-1:0] max_len_q;
  pqm_pkg::state_e state_q, state_d;
  pqm_pkg::req_t req_q;
  pqm_pkg::rsp_t rsp_q, rsp_d;

  logic [CONN_SLOTS-1:0] conn_use_q, conn_use_d, nonempty_q, nonempty_d;
  logic [pqm_pkg::ProtoW-1:0] proto_q [CONN_SLOTS];
  logic [BW-1:0] head_q [CONN_SLOTS];
  logic [BW-1:0] tail_q [CONN_SLOTS];
  logic [BUFFER_COUNT-1:0] buf_use_q, buf_use_d;

  logic [CW:0] cidx_q, cidx_d;
  logic [BW:0] bidx_q, bidx_d;
  logic found_q, found_d, free_found_q, free_found_d;
  logic [CW-1:0] sel_q, sel_d;
  logic [BW-1:0] cur_q, cur_d;
  logic [BW:0] walk_q, walk_d;

  logic proto_we, head_we, tail_we;
  logic [CW-1:0] pw_idx;
  logic [BW-1:0] hw_val;

  logic nxt_we, len_we;
  logic [BW-1:0] nxt_waddr, nxt_wdata, nxt_raddr, nxt_rdata;
  logic [pqm_pkg::LenW-1:0] len_rdata;

  logic [CW-1:0] ci;
  logic slot_ok;

  assign cfg.ready = 1'b1;
  assign req.ready = (state_q == pqm_pkg::S_IDLE);
  assign rsp.valid = (state_q == pqm_pkg::S_OUT);
  assign rsp.data = rsp_q;
  assign ci = cidx_q[CW-1:0];
  assign slot_ok = ({{(32-SlotWx){1'b0}}, req_q.conn_index} < CONN_SLOTS);
  logic [CW-1:0] rslot;
  assign rslot = CW'(req_q.conn_index);

  pqm_ram #(.Width(BW), .Depth(BUFFER_COUNT)) u_next (
    .clk_i, .we_i(nxt_we), .waddr_i(nxt_waddr), .wdata_i(nxt_wdata),
    .raddr_i(nxt_raddr), .rdata_o(nxt_rdata)
  );

  pqm_ram #(.Width(pqm_pkg::LenW), .Depth(BUFFER_COUNT)) u_len (
    .clk_i, .we_i(len_we), .waddr_i(bidx_q[BW-1:0]), .wdata_i(req_q.length),
    .raddr_i(nxt_raddr), .rdata_o(len_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= pqm_pkg::MaxLengthReset;
      state_q <= pqm_pkg::S_IDLE;
      conn_use_q <= '0;
      nonempty_q <= '0;
      buf_use_q <= '0;
    end else begin
      if (cfg.valid) begin
        max_len_q <= cfg.data;
      end
      state_q <= state_d;
      conn_use_q <= conn_use_d;
      nonempty_q <= nonempty_d;
      buf_use_q <= buf_use_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req.valid && req.ready) begin
      req_q <= req.data;
    end
    rsp_q <= rsp_d;
    cidx_q <= cidx_d;
    bidx_q <= bidx_d;
    found_q <= found_d;
    free_found_q <= free_found_d;
    sel_q <= sel_d;
    cur_q <= cur_d;
    walk_q <= walk_d;
    if (proto_we) proto_q[pw_idx] <= req_q.protocol;
    if (head_we) head_q[pw_idx] <= hw_val;
    if (tail_we) tail_q[pw_idx] <= bidx_q[BW-1:0];
  end

  always_comb begin
    state_d = state_q;
    rsp_d = rsp_q;
    conn_use_d = conn_use_q;
    nonempty_d = nonempty_q;
    buf_use_d = buf_use_q;
    cidx_d = cidx_q;
    bidx_d = bidx_q;
    found_d = found_q;
    free_found_d = free_found_q;
    sel_d = sel_q;
    cur_d = cur_q;
    walk_d = walk_q;
    proto_we = 1'b0;
    head_we = 1'b0;
    tail_we = 1'b0;
    pw_idx = sel_q;
    hw_val = bidx_q[BW-1:0];
    nxt_we = 1'b0;
    len_we = 1'b0;
    nxt_waddr = bidx_q[BW-1:0];
    nxt_wdata = '0;
    nxt_raddr = cur_q;
    unique case (state_q)
      pqm_pkg::S_IDLE: begin
        cidx_d = '0;
        bidx_d = '0;
        found_d = 1'b0;
        free_found_d = 1'b0;
        if (req.valid) begin
          rsp_d = '0;
          unique case (pqm_pkg::kind_e'(req.data.kind))
            pqm_pkg::KIND_OPEN: state_d = pqm_pkg::S_CONN_SCAN;
            pqm_pkg::KIND_DELIVER: begin
              if (req.data.length[0] || req.data.length < pqm_pkg::MinLength ||
                  req.data.length > max_len_q) begin
                rsp_d.status = pqm_pkg::ST_BAD_SIZE;
                state_d = pqm_pkg::S_OUT;
              end else begin
                state_d = pqm_pkg::S_BUF_SCAN;
              end
            end
            pqm_pkg::KIND_CLOSE: state_d = pqm_pkg::S_CLOSE_RD;
            default: state_d = pqm_pkg::S_READ_RD;
          endcase
        end
      end
      pqm_pkg::S_BUF_SCAN: begin
        if (!buf_use_q[bidx_q[BW-1:0]]) begin
          state_d = pqm_pkg::S_CONN_SCAN;
        end else if (bidx_q == (BW + 1)'(BUFFER_COUNT - 1)) begin
          rsp_d.status = pqm_pkg::ST_NO_BUFFER;
          state_d = pqm_pkg::S_OUT;
        end else begin
          bidx_d = bidx_q + 1'b1;
        end
      end
      pqm_pkg::S_CONN_SCAN: begin
        if (req_q.kind == pqm_pkg::KIND_OPEN) begin
          if (!conn_use_q[ci]) begin
            if (!free_found_q) begin
              free_found_d = 1'b1;
              sel_d = ci;
            end
          end else if (proto_q[ci] == req_q.protocol) begin
            found_d = 1'b1;
          end
        end else if (!found_q && conn_use_q[ci] && proto_q[ci] == req_q.protocol) begin
          found_d = 1'b1;
          sel_d = ci;
        end
        cidx_d = cidx_q + 1'b1;
        if (cidx_q == (CW + 1)'(CONN_SLOTS - 1)) begin
          state_d = pqm_pkg::S_OUT;
          if (req_q.kind == pqm_pkg::KIND_OPEN) begin
            if (found_d) begin
              rsp_d.status = pqm_pkg::ST_PROTO_IN_USE;
            end else if (!free_found_d) begin
              rsp_d.status = pqm_pkg::ST_NO_FREE_CONN;
            end else begin
              pw_idx = sel_d;
              proto_we = 1'b1;
              conn_use_d[sel_d] = 1'b1;
              nonempty_d[sel_d] = 1'b0;
              rsp_d.conn_result = pqm_pkg::SlotW'(sel_d);
            end
          end else if (!found_d) begin
            rsp_d.status = pqm_pkg::ST_NO_RECEIVER;
          end else begin
            pw_idx = sel_d;
            buf_use_d[bidx_q[BW-1:0]] = 1'b1;
            len_we = 1'b1;
            nxt_we = 1'b1;
            if (nonempty_q[sel_d]) begin
              nxt_waddr = tail_q[sel_d];
              nxt_wdata = bidx_q[BW-1:0];
            end else begin
              head_we = 1'b1;
              nonempty_d[sel_d] = 1'b1;
            end
            tail_we = 1'b1;
            rsp_d.conn_result = pqm_pkg::SlotW'(sel_d);
            rsp_d.packet_index = pqm_pkg::PktW'(bidx_q[BW-1:0]);
            rsp_d.length_result = req_q.length;
          end
        end
      end
      pqm_pkg::S_CLOSE_RD: begin
        if (!slot_ok) begin
          rsp_d.status = pqm_pkg::ST_BAD_HANDLE;
          state_d = pqm_pkg::S_OUT;
        end else begin
          rsp_d.conn_result = req_q.conn_index;
          cur_d = head_q[rslot];
          walk_d = '0;
          if (nonempty_q[rslot]) begin
            nxt_raddr = head_q[rslot];
            state_d = pqm_pkg::S_CLOSE_WALK;
          end else begin
            conn_use_d[rslot] = 1'b0;
            state_d = pqm_pkg::S_OUT;
          end
        end
      end
      pqm_pkg::S_CLOSE_WALK: begin
        buf_use_d[cur_q] = 1'b0;
        cur_d = nxt_rdata;
        nxt_raddr = nxt_rdata;
        walk_d = walk_q + 1'b1;
        if (cur_q == tail_q[rslot] || walk_q == (BW + 1)'(BUFFER_COUNT - 1)) begin
          nonempty_d[rslot] = 1'b0;
          conn_use_d[rslot] = 1'b0;
          state_d = pqm_pkg::S_OUT;
        end
      end
      pqm_pkg::S_READ_RD: begin
        if (!slot_ok || !conn_use_q[rslot]) begin
          rsp_d.status = pqm_pkg::ST_BAD_HANDLE;
          state_d = pqm_pkg::S_OUT;
        end else if (!nonempty_q[rslot]) begin
          rsp_d.status = pqm_pkg::ST_EMPTY;
          rsp_d.conn_result = req_q.conn_index;
          state_d = pqm_pkg::S_OUT;
        end else begin
          cur_d = head_q[rslot];
          nxt_raddr = head_q[rslot];
          state_d = pqm_pkg::S_READ_DONE;
        end
      end
      pqm_pkg::S_READ_DONE: begin
        pw_idx = rslot;
        if (cur_q == tail_q[rslot]) begin
          nonempty_d[rslot] = 1'b0;
        end else begin
          head_we = 1'b1;
          hw_val = nxt_rdata;
        end
        buf_use_d[cur_q] = 1'b0;
        rsp_d.conn_result = req_q.conn_index;
        rsp_d.packet_index = pqm_pkg::PktW'(cur_q);
        rsp_d.length_result = len_rdata;
        rsp_d.status = (req_q.length < len_rdata) ? pqm_pkg::ST_WINDOW_SMALL
                                                  : pqm_pkg::ST_OK;
        state_d = pqm_pkg::S_OUT;
      end
      pqm_pkg::S_OUT: begin
        if (rsp.ready) state_d = pqm_pkg::S_IDLE;
      end
      default: state_d = pqm_pkg::S_IDLE;
    endcase
  end

endmodule
